/* rtl/psc_pkg.sv */
// Package of the pot scanline comparator: constants, codes and shared types.
package psc_pkg;

	localparam int LINES_PER_FRAME = 262;
	localparam int IRQ_LINE_STEP   = 64;
	localparam int POT_LINE_LIMIT  = 256;
	localparam int NUM_POTS        = 6;
	localparam int LINE_W          = 9;
	localparam int POT_W           = 8;
	localparam int BYTE_W          = 8;
	localparam logic [BYTE_W-1:0] INV_MASK  = 8'h3f;
	localparam logic [BYTE_W-1:0] TIMER_BIT = 8'h02;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 24;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COINAGE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUND_TIME = 2'd2;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_SW_READ   = 3'd1,
		OP_MISC_READ = 3'd2,
		OP_LATCH_WR  = 3'd3,
		OP_IRQ_CLR   = 3'd4
	} psc_op_t;

	typedef enum logic [1:0] {
		MISC_FIRED   = 2'd0,
		MISC_LINE    = 2'd1,
		MISC_ROUNDS  = 2'd2,
		MISC_COINAGE = 2'd3
	} psc_misc_t;

	typedef struct packed {
		logic [1:0]        rounds;
		logic [1:0]        coinage;
		logic [BYTE_W-1:0] round_time;
	} psc_cfg_t;

	typedef struct packed {
		logic [LINE_W-1:0]                 line;
		logic [NUM_POTS-1:0][POT_W-1:0]    pot;
		logic [NUM_POTS-1:0]               fired;
		logic [NUM_POTS-1:0]               latch;
		logic                              irq;
		logic                              nmi;
	} psc_state_t;

	typedef struct packed {
		logic [2:0]                     op;
		logic [2:0]                     offset;
		logic [BYTE_W-1:0]              write_data;
		logic [BYTE_W-1:0]              switches;
		logic [NUM_POTS-1:0][POT_W-1:0] pots;
	} psc_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              irq_level;
		logic              nmi_level;
		logic [LINE_W-1:0] line_now;
	} psc_result_t;

endpackage

/* rtl/psc_core.sv */
// Next-state and result logic for one beat of the pot scanline comparator.
module psc_core
	import psc_pkg::*;
(
	input  psc_state_t  cur,
	input  psc_item_t   item,
	input  psc_cfg_t    cfg,
	output psc_state_t  nxt,
	output psc_result_t res
);

	logic [LINE_W-1:0] line_inc;
	logic [BYTE_W-1:0] sw_eff;
	logic [BYTE_W-1:0] misc_val;

	assign line_inc = cur.line + LINE_W'(1);

	always_comb begin
		sw_eff = item.switches;
		if ({1'b0, cfg.round_time} < cur.line) begin
			sw_eff = item.switches | TIMER_BIT;
		end
	end

	always_comb begin
		unique case (psc_misc_t'(item.offset[1:0]))
			MISC_FIRED:   misc_val = {2'b00, cur.fired & cur.latch};
			MISC_LINE:    misc_val = cur.line[BYTE_W-1:0];
			MISC_ROUNDS:  misc_val = {6'b0, cfg.rounds};
			MISC_COINAGE: misc_val = {6'b0, cfg.coinage};
		endcase
	end

	always_comb begin
		nxt = cur;
		res.read_data = '0;
		unique case (psc_op_t'(item.op))
			OP_TICK: begin
				if (line_inc >= LINE_W'(LINES_PER_FRAME)) begin
					nxt.line = '0;
				end else begin
					nxt.line = line_inc;
				end
				if ((nxt.line % LINE_W'(IRQ_LINE_STEP)) == '0) begin
					nxt.irq = 1'b1;
				end
				if (nxt.line == '0) begin
					nxt.pot   = item.pots;
					nxt.fired = '0;
				end else if (nxt.line < LINE_W'(POT_LINE_LIMIT)) begin
					for (int i = 0; i < NUM_POTS; i++) begin
						if ({1'b0, cur.pot[i]} == nxt.line) begin
							nxt.fired[i] = 1'b1;
							if (cur.latch[i]) begin
								nxt.nmi = 1'b1;
							end
						end
					end
				end
			end
			OP_SW_READ: begin
				res.read_data = {sw_eff[item.offset], 7'b0};
			end
			OP_MISC_READ: begin
				res.read_data = misc_val ^ INV_MASK;
			end
			OP_LATCH_WR: begin
				nxt.latch = item.write_data[NUM_POTS-1:0];
				nxt.nmi   = 1'b0;
			end
			OP_IRQ_CLR: begin
				nxt.irq = 1'b0;
			end
			default: begin
			end
		endcase
		res.irq_level = nxt.irq;
		res.nmi_level = nxt.nmi;
		res.line_now  = nxt.line;
	end

endmodule

/* rtl/pot_scanline_comparator_io_top.sv */
// Top level of the pot scanline comparator: handshake, state and config registers.
//
// Input stream (s_*): one beat per tick or bus access. tdata carries op, offset,
// write_data, switches and the six pot readings. Output stream (m_*): exactly one
// beat per input beat, carrying read_data, irq_level, nmi_level and line_now.
// Config port (cfg_*): rounds, coinage and round-time registers, written when
// cfg_we is high; index 3 is ignored.
//
// Output is registered: a beat accepted at one edge shows on m_* the cycle after.
// Throughput is one beat per cycle; all state updates happen at the accepting
// edge in a single pass of compare and mux logic, and the result sits in one
// output register. s_tready is high while that register is empty or is being
// taken, so the block keeps accepting while a result is drained. When the
// receiver stalls, the result is held and s_tready stays low until it is taken.
//
// Reset clears the interrupt flags, latch, fired bits and pots, sets the line
// counter to the last line of the frame (first tick enters line 0) and loads
// the register defaults (rounds 1, coinage 1, round time 92).
module pot_scanline_comparator_io_top
	import psc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// op[2:0], offset[5:3], write_data[13:6], switches[21:14], pot_h1[29:22],
	// pot_v1[37:30], pot_r1[45:38], pot_h2[53:46], pot_v2[61:54], pot_r2[69:62]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// read_data[7:0], irq_level[8], nmi_level[9], line_now[18:10]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [BYTE_W-1:0]      cfg_wdata
);

	psc_state_t  state_q;
	psc_state_t  state_nxt;
	psc_cfg_t    cfg_q;
	psc_item_t   item;
	psc_result_t res;
	psc_result_t res_q;
	logic        m_tvalid_q;
	logic        s_fire;

	always_comb begin
		item.op         = s_tdata[2:0];
		item.offset     = s_tdata[5:3];
		item.write_data = s_tdata[13:6];
		item.switches   = s_tdata[21:14];
		for (int i = 0; i < NUM_POTS; i++) begin
			item.pots[i] = s_tdata[22 + i*POT_W +: POT_W];
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	psc_core u_core (
		.cur  (state_q),
		.item (item),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.line  <= LINE_W'(LINES_PER_FRAME - 1);
			state_q.pot   <= '0;
			state_q.fired <= '0;
			state_q.latch <= '0;
			state_q.irq   <= 1'b0;
			state_q.nmi   <= 1'b0;
		end else if (s_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rounds     <= 2'd1;
			cfg_q.coinage    <= 2'd1;
			cfg_q.round_time <= 8'd92;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROUNDS) begin
				cfg_q.rounds <= cfg_wdata[1:0];
			end else if (cfg_index == CFG_COINAGE) begin
				cfg_q.coinage <= cfg_wdata[1:0];
			end else if (cfg_index == CFG_ROUND_TIME) begin
				cfg_q.round_time <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, res_q.line_now, res_q.nmi_level, res_q.irq_level,
		res_q.read_data};

`ifndef NO_ASSERTIONS
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line < LINE_W'(LINES_PER_FRAME))
		else $error("line counter out of frame");

	a_irq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && item.op == OP_IRQ_CLR |=> !m_tdata[8] && !state_q.irq)
		else $error("irq not cleared");

	a_latch_wr: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && item.op == OP_LATCH_WR |=> !m_tdata[9] && !state_q.nmi)
		else $error("nmi not cleared by latch write");

	a_fired_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_fire && item.op == OP_TICK) |=> $stable(state_q.fired))
		else $error("fired bits changed without tick");

	a_nmi_needs_latch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.nmi |-> state_q.latch != '0)
		else $error("nmi set with empty latch");
`endif

endmodule
